>>> rtl/core/blt_pkg.sv
// Shared types and constants for the block language tokenizer.
// Used by blt_front, blt_queue, blt_back and block_language_tokenizer.
package blt_pkg;

   localparam int MaxBlockDepthDefault   = 255;
   localparam int MaxCommentDepthDefault = 255;
   localparam int LineLengthDefault      = 256;

   localparam logic [1:0] CMD_CHAR  = 2'd0;
   localparam logic [1:0] CMD_CHECK = 2'd1;
   localparam logic [1:0] CMD_BEGIN = 2'd2;

   localparam logic [2:0] K_OPEN  = 3'd0;
   localparam logic [2:0] K_CLOSE = 3'd1;
   localparam logic [2:0] K_WORD  = 3'd2;
   localparam logic [2:0] K_COND  = 3'd3;
   localparam logic [2:0] K_LOOP  = 3'd4;
   localparam logic [2:0] K_EOL   = 3'd5;
   localparam logic [2:0] K_ERR   = 3'd6;
   localparam logic [2:0] K_OK    = 3'd7;

   localparam logic [3:0] E_NONE    = 4'd0;
   localparam logic [3:0] E_COMMENT = 4'd1;
   localparam logic [3:0] E_BYTE    = 4'd2;
   localparam logic [3:0] E_HEX     = 4'd3;
   localparam logic [3:0] E_SIGN    = 4'd4;
   localparam logic [3:0] E_WORD    = 4'd5;
   localparam logic [3:0] E_COND    = 4'd6;
   localparam logic [3:0] E_CLOSE   = 4'd7;
   localparam logic [3:0] E_OPEN    = 4'd8;
   localparam logic [3:0] E_DEEP    = 4'd9;

   localparam logic [4:0] OP_INC = 5'd14;
   localparam logic [4:0] OP_DEC = 5'd15;
   localparam logic [4:0] OP_SHL = 5'd16;

   typedef enum logic [4:0] {
      P_START, P_CR, P_COMMENT, P_PREFIX, P_SIGN, P_DEC, P_HEX0, P_HEX,
      P_NAME, P_NAME_I, P_NAME_IF, P_OPDBL, P_WEND, P_COND_LT, P_COND_GT,
      P_COND_EQ, P_AFTER0, P_LOOP, P_LOOPEND
   } phase_type;

   // One token result as produced by the front and queued for the back.
   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  prefix;
      logic [15:0] value;
      logic        is_name;
      logic [4:0]  word_op;
      logic [2:0]  cond_op;
      logic [7:0]  column;
      logic [3:0]  error_code;
      logic [7:0]  depth;
      logic        last;
   } result_type;

   // Both results caused by one character; n is the count (0..2).
   typedef struct packed {
      logic [1:0]  n;
      result_type  r0;
      result_type  r1;
   } group_type;

   function automatic logic [4:0] op_index(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      case (c)
         8'h2B: r = 5'd1;  8'h2D: r = 5'd2;  8'h26: r = 5'd3;  8'h7C: r = 5'd4;
         8'h5E: r = 5'd5;  8'h3D: r = 5'd6;  8'h2E: r = 5'd7;  8'h2C: r = 5'd8;
         8'h3A: r = 5'd9;  8'h3B: r = 5'd10; 8'h3F: r = 5'd11; 8'h21: r = 5'd12;
         8'h3C: r = 5'd13;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Returns 16 when the byte is no hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
      return r;
   endfunction

endpackage

>>> rtl/core/blt_front.sv
// Front part: accepts characters and runs the tokenizer state machine.
// Depends on blt_pkg; pushes result groups into blt_queue.
module blt_front import blt_pkg::*; #(
   parameter int MAX_BLOCK_DEPTH   = MaxBlockDepthDefault,
   parameter int MAX_COMMENT_DEPTH = MaxCommentDepthDefault,
   parameter int LINE_LENGTH       = LineLengthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [1:0]  in_cmd,
   input  logic [7:0]  in_ch,
   input  logic        q_full,
   output logic        q_push,
   output group_type   q_data
);

   localparam int BdW = $clog2(MAX_BLOCK_DEPTH + 1);
   localparam int CdW = $clog2(MAX_COMMENT_DEPTH + 1);
   localparam int PosLimit = (LINE_LENGTH - 1) < 255 ? (LINE_LENGTH - 1) : 255;

   phase_type   phase_ff, phase_in;
   logic [BdW-1:0] bdepth_ff, bdepth_in;
   logic [CdW-1:0] cdepth_ff, cdepth_in;
   logic [15:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [2:0]  pfx_ff, pfx_in;
   logic [4:0]  hop_ff, hop_in;
   logic [2:0]  lmatch_ff, lmatch_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  tstart_ff, tstart_in;
   logic        skip_ff, skip_in;
   logic        wname_ff, wname_in;

   logic        fire;
   logic [7:0]  c;
   group_type   g;

   assign in_ready = !q_full;
   assign fire     = in_valid && in_ready;
   assign c        = in_ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_START; bdepth_ff <= '0; cdepth_ff <= '0; acc_ff <= '0;
         neg_ff <= 1'b0; pfx_ff <= '0; hop_ff <= '0; lmatch_ff <= '0;
         pos_ff <= '0; tstart_ff <= '0; skip_ff <= 1'b0; wname_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in; bdepth_ff <= bdepth_in; cdepth_ff <= cdepth_in;
         acc_ff <= acc_in; neg_ff <= neg_in; pfx_ff <= pfx_in; hop_ff <= hop_in;
         lmatch_ff <= lmatch_in; pos_ff <= pos_in; tstart_ff <= tstart_in;
         skip_ff <= skip_in; wname_ff <= wname_in;
      end
   end

   always_comb begin : step
      logic is_print, has_more, is_digit, is_alpha, is_namech;
      logic [4:0] hv, oi;
      logic do_start, do_body, sign_ok, do_wend, do_tail, do_cend;
      logic [2:0] ckind;
      logic [7:0] cur;
      logic [15:0] v;
      logic [7:0] lpc;
      result_type r;

      phase_in = phase_ff; bdepth_in = bdepth_ff; cdepth_in = cdepth_ff;
      acc_in = acc_ff; neg_in = neg_ff; pfx_in = pfx_ff; hop_in = hop_ff;
      lmatch_in = lmatch_ff; pos_in = pos_ff; tstart_in = tstart_ff;
      skip_in = skip_ff; wname_in = wname_ff;
      g = '0;
      cur = pos_ff;
      is_print = (c >= 8'h20) && (c <= 8'h7E);
      has_more = is_print && c != 8'h5B && c != 8'h7B;
      is_digit = (c >= 8'h30) && (c <= 8'h39);
      is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
      is_namech = is_alpha || is_digit || c == 8'h5F;
      hv = hex_val(c);
      oi = op_index(c);
      do_start = 1'b0; do_body = 1'b0; sign_ok = 1'b1;
      do_wend = 1'b0; do_tail = 1'b0; do_cend = 1'b0; ckind = K_COND;
      v = '0; r = '0;
      // A character never yields program ok, so that kind marks r as empty.
      r.kind = K_OK;
      case (lmatch_ff[1:0])
         2'd0: lpc = 8'h6C; 2'd1: lpc = 8'h6F; 2'd2: lpc = 8'h6F;
         default: lpc = 8'h70;
      endcase

      if (in_cmd == CMD_BEGIN) begin
         phase_in = P_START; bdepth_in = '0; cdepth_in = '0; acc_in = '0;
         neg_in = 1'b0; pfx_in = '0; hop_in = '0; lmatch_in = '0; pos_in = '0;
         tstart_in = '0; skip_in = 1'b0; wname_in = 1'b0;
      end else if (in_cmd == CMD_CHECK) begin
         phase_in = P_START; cdepth_in = '0; acc_in = '0; neg_in = 1'b0;
         pfx_in = '0; hop_in = '0; lmatch_in = '0; wname_in = 1'b0;
         skip_in = 1'b0; pos_in = '0;
         r.kind = (bdepth_ff != '0) ? K_ERR : K_OK;
         r.error_code = (bdepth_ff != '0) ? E_OPEN : E_NONE;
         r.depth = 8'(bdepth_ff);
         g.r0 = r; g.n = 2'd1;
      end else if (in_cmd == CMD_CHAR) begin
         if (!skip_ff) begin
            // Token continuation: may close a pending token and restart.
            case (phase_ff)
               P_START:  do_start = 1'b1;
               P_CR: begin
                  if (c == 8'h0A) phase_in = P_START;
                  else begin
                     r.kind = K_ERR; r.error_code = E_WORD;
                  end
               end
               P_COMMENT: begin
                  if (c == 8'h00) begin r.kind = K_ERR; r.error_code = E_COMMENT; end
                  else if (!is_print) begin r.kind = K_ERR; r.error_code = E_BYTE; end
                  else if (c == 8'h7B) begin
                     if (32'(cdepth_ff) >= MAX_COMMENT_DEPTH) begin
                        r.kind = K_ERR; r.error_code = E_DEEP;
                     end else cdepth_in = cdepth_ff + 1'b1;
                  end else if (c == 8'h7D) begin
                     if (cdepth_ff <= CdW'(1)) begin
                        cdepth_in = '0; phase_in = P_START;
                     end else cdepth_in = cdepth_ff - 1'b1;
                  end
               end
               P_PREFIX: do_body = 1'b1;
               P_SIGN: begin do_body = 1'b1; sign_ok = 1'b0; end
               P_DEC: begin
                  if (is_digit) acc_in = 16'((acc_ff << 3) + (acc_ff << 1) + 16'(c - 8'h30));
                  else do_tail = 1'b1;
               end
               P_HEX0: begin
                  if (!hv[4]) begin acc_in = 16'(hv); phase_in = P_HEX; end
                  else begin r.kind = K_ERR; r.error_code = E_HEX; end
               end
               P_HEX: begin
                  if (!hv[4]) acc_in = {acc_ff[11:0], hv[3:0]};
                  else do_tail = 1'b1;
               end
               P_NAME, P_NAME_I, P_NAME_IF: begin
                  if (is_namech) begin
                     if (acc_ff != 16'hFFFF) acc_in = acc_ff + 16'd1;
                     phase_in = (phase_ff == P_NAME_I && c == 8'h66) ? P_NAME_IF : P_NAME;
                  end else if (phase_ff == P_NAME_IF && pfx_ff == 3'd0) begin
                     if (c == 8'h3C) begin hop_in = 5'd1; phase_in = P_COND_LT; end
                     else if (c == 8'h3E) begin hop_in = 5'd2; phase_in = P_COND_GT; end
                     else if (c == 8'h3D) begin hop_in = 5'd3; phase_in = P_COND_EQ; end
                     else begin r.kind = K_ERR; r.error_code = E_COND; end
                  end else do_tail = 1'b1;
               end
               P_OPDBL: begin
                  if ((hop_ff == 5'd1 && c == 8'h2B) || (hop_ff == 5'd2 && c == 8'h2D) ||
                      (hop_ff == 5'd13 && c == 8'h3C)) begin
                     hop_in = (hop_ff == 5'd1) ? OP_INC : (hop_ff == 5'd2) ? OP_DEC : OP_SHL;
                     phase_in = P_WEND;
                  end else do_wend = 1'b1;
               end
               P_WEND: do_wend = 1'b1;
               P_COND_LT: begin
                  if (c == 8'h3E) begin hop_in = 5'd4; phase_in = P_COND_EQ; end
                  else if (c == 8'h3D) begin hop_in = 5'd5; phase_in = P_COND_EQ; end
                  else if (c == 8'h30) phase_in = P_AFTER0;
                  else begin r.kind = K_ERR; r.error_code = E_COND; end
               end
               P_COND_GT: begin
                  if (c == 8'h3D) begin hop_in = 5'd6; phase_in = P_COND_EQ; end
                  else if (c == 8'h30) phase_in = P_AFTER0;
                  else begin r.kind = K_ERR; r.error_code = E_COND; end
               end
               P_COND_EQ: begin
                  if (c == 8'h30) phase_in = P_AFTER0;
                  else begin r.kind = K_ERR; r.error_code = E_COND; end
               end
               P_AFTER0: begin
                  if (c == 8'h6C) begin lmatch_in = 3'd1; phase_in = P_LOOP; end
                  else do_cend = 1'b1;
               end
               P_LOOP: begin
                  if (c == lpc) begin
                     lmatch_in = lmatch_ff + 3'd1;
                     if (lmatch_ff >= 3'd3) phase_in = P_LOOPEND;
                  end else begin r.kind = K_ERR; r.error_code = E_COND; end
               end
               P_LOOPEND: begin do_cend = 1'b1; ckind = K_LOOP; end
               default: phase_in = P_START;
            endcase

            if (do_tail) begin
               if (oi != 5'd0) begin
                  hop_in = oi;
                  phase_in = (c == 8'h2B || c == 8'h2D || c == 8'h3C) ? P_OPDBL : P_WEND;
               end else do_wend = 1'b1;
            end
            if (do_wend) begin
               if (has_more) begin r.kind = K_ERR; r.error_code = E_WORD; end
               else begin
                  v = (!wname_ff && neg_ff) ? 16'(16'd0 - acc_ff) : acc_ff;
                  g.r0.kind = K_WORD; g.r0.prefix = pfx_ff; g.r0.value = v;
                  g.r0.is_name = wname_ff; g.r0.word_op = hop_in;
                  g.r0.column = tstart_ff; g.n = 2'd1;
                  do_start = 1'b1;
               end
            end
            if (do_cend) begin
               if (has_more) begin r.kind = K_ERR; r.error_code = E_COND; end
               else begin
                  g.r0.kind = ckind; g.r0.cond_op = 3'(hop_ff);
                  g.r0.column = tstart_ff; g.n = 2'd1;
                  do_start = 1'b1;
               end
            end
            if (do_start) begin
               // Clear the token, then classify c as a fresh token start.
               phase_in = P_START; acc_in = '0; neg_in = 1'b0; pfx_in = '0;
               hop_in = '0; lmatch_in = '0; wname_in = 1'b0; cdepth_in = '0;
               tstart_in = cur;
               if (c == 8'h00 || c == 8'h20 || c == 8'h0A) begin
               end else if (c == 8'h0D) phase_in = P_CR;
               else if (c == 8'h7B) begin cdepth_in = CdW'(1); phase_in = P_COMMENT; end
               else if (c == 8'h5B) begin
                  if (32'(bdepth_ff) >= MAX_BLOCK_DEPTH) begin
                     r.kind = K_ERR; r.error_code = E_DEEP;
                  end else begin
                     bdepth_in = bdepth_ff + 1'b1;
                     r.kind = K_OPEN;
                  end
               end else if (c == 8'h5D) begin
                  if (bdepth_ff == '0) begin r.kind = K_ERR; r.error_code = E_CLOSE; end
                  else begin bdepth_in = bdepth_ff - 1'b1; r.kind = K_CLOSE; end
               end else if (c == 8'h3C) begin pfx_in = 3'd1; phase_in = P_PREFIX; end
               else if (c == 8'h3E) begin pfx_in = 3'd2; phase_in = P_PREFIX; end
               else if (c == 8'h5C) begin pfx_in = 3'd3; phase_in = P_PREFIX; end
               else if (c == 8'h25) begin pfx_in = 3'd4; phase_in = P_PREFIX; end
               else do_body = 1'b1;
            end
            if (do_body) begin
               if (sign_ok && (c == 8'h2D || c == 8'h2B)) begin
                  neg_in = (c == 8'h2D); phase_in = P_SIGN;
               end else if (is_digit) begin
                  acc_in = 16'(c - 8'h30); phase_in = P_DEC;
               end else if (c == 8'h24) phase_in = P_HEX0;
               else if (!sign_ok) begin r.kind = K_ERR; r.error_code = E_SIGN; end
               else if (is_alpha) begin
                  acc_in = 16'd1; wname_in = 1'b1;
                  phase_in = (c == 8'h69) ? P_NAME_I : P_NAME;
               end else begin r.kind = K_ERR; r.error_code = E_WORD; end
            end
            // r holds an open, close or error raised by this character.
            if (r.kind != K_OK) begin
               if (r.kind != K_ERR || r.error_code != E_NONE) begin
                  r.column = tstart_in;
                  r.depth = 8'(bdepth_in);
                  if (r.kind == K_ERR) begin
                     phase_in = P_START; acc_in = '0; neg_in = 1'b0; pfx_in = '0;
                     hop_in = '0; lmatch_in = '0; wname_in = 1'b0; cdepth_in = '0;
                     skip_in = 1'b1;
                  end
                  if (g.n == 2'd0) begin g.r0 = r; g.n = 2'd1; end
                  else begin g.r1 = r; g.n = 2'd2; end
               end
            end
         end
         if (g.n != 2'd0) begin
            g.r0.depth = (g.n == 2'd1 && g.r0.kind != K_WORD && g.r0.kind != K_COND &&
                          g.r0.kind != K_LOOP) ? g.r0.depth : 8'(bdepth_ff);
         end
         if (c == 8'h00) begin
            r = '0;
            r.kind = K_EOL; r.column = cur; r.depth = 8'(bdepth_in);
            if (g.n == 2'd0) begin g.r0 = r; g.n = 2'd1; end
            else begin g.r1 = r; g.n = 2'd2; end
            phase_in = P_START; acc_in = '0; neg_in = 1'b0; pfx_in = '0;
            hop_in = '0; lmatch_in = '0; wname_in = 1'b0; cdepth_in = '0;
            skip_in = 1'b0; pos_in = '0;
         end else if (32'(pos_ff) < PosLimit) pos_in = pos_ff + 8'd1;
      end
      if (g.n == 2'd1) g.r0.last = 1'b1;
      if (g.n == 2'd2) g.r1.last = 1'b1;
   end

   assign q_push = fire && (q_data.n != 2'd0);
   assign q_data = g;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      32'(bdepth_ff) <= MAX_BLOCK_DEPTH) else $error("block depth out of range");
   a_skip_clear: assert property (@(posedge clock) disable iff (reset)
      fire && in_cmd == CMD_CHAR && in_ch == 8'h00 |=> !skip_ff)
      else $error("skip survives line end");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");
`endif

endmodule

>>> rtl/core/blt_queue.sv
// Short FIFO of result groups between front and back.
// Depends on blt_pkg.
module blt_queue import blt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output group_type head
);

   group_type  slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
   end

`ifndef SYNTHESIS
   a_no_under: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !full) else $error("push into full queue");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
`endif

endmodule

>>> rtl/core/blt_back.sv
// Back part: unpacks queued result groups into single result transfers.
// Depends on blt_pkg.
module blt_back import blt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  group_type  q_head,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic sel_ff, sel_in;
   logic take;

   assign out_valid = q_valid;
   assign out_data  = sel_ff ? q_head.r1 : q_head.r0;
   assign take      = out_valid && out_ready;
   assign q_pop     = take && (sel_ff || q_head.n == 2'd1);

   always_comb begin
      sel_in = sel_ff;
      if (take) sel_in = !q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) sel_ff <= 1'b0;
      else       sel_ff <= sel_in;
   end

`ifndef SYNTHESIS
   a_sel_two: assert property (@(posedge clock) disable iff (reset)
      sel_ff && q_valid |-> q_head.n == 2'd2) else $error("second result of single group");
   a_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> out_data.last) else $error("group popped before last result");
   a_sel_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(sel_ff)) else $error("selector moved without transfer");
`endif

endmodule

>>> rtl/core/block_language_tokenizer.sv
// Channel   Dir  Ports                    Contents
// req       in   req_tvalid/tready/tuser  tuser: cmd[1:0]; tdata: ch[7:0]
// rsp       out  rsp_tvalid/tready/tuser  tuser: kind, is_name; tdata: token fields; tlast
//
// One character is accepted per cycle while the queue has room; the classifying state
// machine in the front does all work for a character in that cycle. Results pass a
// two-entry queue and leave one per cycle while rsp_tready is high, so a character
// yielding two results leaves as two transfers. Reset is synchronous and clears all
// control state. Either side may stall independently while the queue has room.
// Top level: depends on blt_pkg, blt_front, blt_queue, blt_back.
module block_language_tokenizer import blt_pkg::*; #(
   parameter int MAX_BLOCK_DEPTH   = MaxBlockDepthDefault,
   parameter int MAX_COMMENT_DEPTH = MaxCommentDepthDefault,
   parameter int LINE_LENGTH       = LineLengthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch[7:0]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // prefix[2:0] value[18:3] word_op[23:19] cond_op[26:24] column[34:27]
   // error_code[38:35] depth[46:39], zero above
   output logic [47:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // kind[2:0] is_name[3]
   output logic        rsp_tlast
);

   group_type  q_in, q_head;
   logic       q_push, q_full, q_pop, q_ne;
   result_type r;

   blt_front #(
      .MAX_BLOCK_DEPTH(MAX_BLOCK_DEPTH), .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH),
      .LINE_LENGTH(LINE_LENGTH)
   ) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(req_tuser), .in_ch(req_tdata), .q_full(q_full), .q_push(q_push),
      .q_data(q_in)
   );

   blt_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .head(q_head)
   );

   blt_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_ne), .q_head(q_head), .q_pop(q_pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(r)
   );

   assign rsp_tdata = {1'b0, r.depth, r.error_code, r.column, r.cond_op, r.word_op,
                       r.value, r.prefix};
   assign rsp_tuser = {r.is_name, r.kind};
   assign rsp_tlast = r.last;

endmodule
